[rtl/tgdh_pkg.sv]
// Shared constants, types and stream layout of the triangle grid histogram.
`timescale 1ns / 1ps
`default_nettype none

package tgdh_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_SUBDIV  = 16;
    localparam int DEF_NUM_SCALES  = 4;
    localparam int DEF_NUM_CLASSES = 8;
    localparam int DEF_COUNT_BITS  = 24;

    // Field widths of the stream items.
    localparam int SUBDIV_W     = 5;
    localparam int COORD_W      = 18;
    localparam int FRAC_BITS    = 16;
    localparam int SCALE_W      = 2;
    localparam int CLASS_W      = 3;
    localparam int READ_CELL_W  = 9;
    localparam int OUT_CELL_W   = 9;
    localparam int OUT_COUNT_W  = 24;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = 5'd8;

    // Request kinds carried in s_tuser.
    localparam logic REQ_BIN  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic mul;
        logic calc;
        logic addr;
        logic read;
        logic update;
        logic clr;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } status_t;

endpackage : tgdh_pkg

`default_nettype wire

[rtl/tgdh_ctrl.sv]
// Sequencing state machine of the triangle grid histogram.
`timescale 1ns / 1ps
`default_nettype none

module tgdh_ctrl
    import tgdh_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_CELL   = 7'b0001000,
        ST_ADDR   = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_CELL;
            end
            ST_CELL: begin
                cmd.calc   = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // Hold here until the output register can take the result.
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule : tgdh_ctrl

`default_nettype wire

[rtl/tgdh_dp.sv]
// Datapath of the triangle grid histogram: cell arithmetic, count store, result register.
`timescale 1ns / 1ps
`default_nettype none

module tgdh_dp
    import tgdh_pkg::*;
#(
    parameter int MAX_SUBDIV  = DEF_MAX_SUBDIV,
    parameter int NUM_SCALES  = DEF_NUM_SCALES,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [SUBDIV_W-1:0]    cfg_wr_data,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,
    output logic                        m_tuser,
    input  wire cmd_t                   cmd,
    output status_t                     status
);

    localparam int CELLS       = MAX_SUBDIV * (MAX_SUBDIV + 1);
    localparam int STORE_DEPTH = NUM_SCALES * CELLS * NUM_CLASSES;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CELL_W      = ($clog2(CELLS) > READ_CELL_W) ? $clog2(CELLS) : READ_CELL_W;
    localparam int PROD_W      = 27;
    localparam int WHOLE_W     = PROD_W - FRAC_BITS;
    localparam int XSQ_W       = 2 * SUBDIV_W + 1;
    localparam int SUM_W       = XSQ_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration and captured request.
    logic [SUBDIV_W-1:0]    subdiv_reg;
    logic                   req_reg;
    logic [COORD_W-1:0]     a_reg, b_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [CLASS_W-1:0]     class_reg;
    logic [READ_CELL_W-1:0] rcell_reg;

    // Pipeline registers of the item in flight.
    logic signed [PROD_W-1:0] c_reg, d_reg, c_next, d_next;
    logic [CELL_W-1:0]        cell_reg, cell_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic                     hit_reg, hit_next;
    logic [COUNT_BITS-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [OUT_CELL_W-1:0]    out_cell_reg;
    logic [OUT_COUNT_W-1:0]   out_count_reg;
    logic                     out_sat_reg;

    logic [COUNT_BITS-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subdiv_reg <= SUBDIV_RESET;
        end else if (cfg_wr_en) begin
            subdiv_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_tuser;
            a_reg     <= s_tdata[COORD_W-1:0];
            b_reg     <= s_tdata[2*COORD_W-1:COORD_W];
            scale_reg <= s_tdata[2*COORD_W+SCALE_W-1:2*COORD_W];
            class_reg <= s_tdata[2*COORD_W+SCALE_W+CLASS_W-1:2*COORD_W+SCALE_W];
            rcell_reg <= s_tdata[2*COORD_W+SCALE_W+CLASS_W+READ_CELL_W-1:
                                 2*COORD_W+SCALE_W+CLASS_W];
        end
    end

    // Effective subdivision count: zero acts as one, large values stop at the maximum.
    logic [SUBDIV_W-1:0] n_eff;
    always_comb begin
        if (subdiv_reg == '0) begin
            n_eff = SUBDIV_W'(1);
        end else if (int'(subdiv_reg) > MAX_SUBDIV) begin
            n_eff = SUBDIV_W'(MAX_SUBDIV);
        end else begin
            n_eff = subdiv_reg;
        end
    end

    // Scaled barycentric coordinates c = n(1-a), d = n(1-a-b) in Q16.
    logic signed [19:0]       diff_a;
    logic signed [20:0]       diff_ab;
    logic signed [SUBDIV_W:0] n_s;
    always_comb begin
        n_s     = $signed({1'b0, n_eff});
        diff_a  = 20'sd65536 - $signed({{2{a_reg[COORD_W-1]}}, a_reg});
        diff_ab = 21'sd65536 - $signed({{3{a_reg[COORD_W-1]}}, a_reg})
                             - $signed({{3{b_reg[COORD_W-1]}}, b_reg});
        c_next  = PROD_W'(n_s * diff_a);
        d_next  = PROD_W'(n_s * diff_ab);
    end

    // Floor, upper/lower choice, clamp into the triangle and cell number.
    logic signed [WHOLE_W-1:0] x_raw, y_raw, n_w;
    logic [FRAC_BITS-1:0]      fc, fd;
    logic [SUBDIV_W-1:0]       xc, yc;
    logic                      lower;
    logic [XSQ_W-1:0]          x_sq;
    logic [SUM_W-1:0]          cell_sum;
    always_comb begin
        x_raw = c_reg[PROD_W-1:FRAC_BITS];
        y_raw = d_reg[PROD_W-1:FRAC_BITS];
        fc    = c_reg[FRAC_BITS-1:0];
        fd    = d_reg[FRAC_BITS-1:0];
        n_w   = $signed(WHOLE_W'(n_eff));
        lower = (fc > fd);
        if (x_raw >= n_w) begin
            xc    = n_eff - SUBDIV_W'(1);
            lower = 1'b1;
        end else if (x_raw < 0) begin
            xc    = '0;
            lower = 1'b1;
        end else begin
            xc = x_raw[SUBDIV_W-1:0];
        end
        if (y_raw >= n_w) begin
            yc    = n_eff - SUBDIV_W'(1);
            lower = 1'b1;
        end else if (y_raw < 0) begin
            yc    = '0;
            lower = 1'b1;
        end else begin
            yc = y_raw[SUBDIV_W-1:0];
        end
        if (yc > xc) begin
            yc    = xc;
            lower = 1'b1;
        end
        x_sq     = XSQ_W'(xc) * (XSQ_W'(xc) + XSQ_W'(1));
        cell_sum = SUM_W'(x_sq) + SUM_W'({yc, 1'b0}) + SUM_W'(lower);
        if (req_reg == REQ_READ) begin
            cell_next = CELL_W'(rcell_reg);
        end else begin
            cell_next = CELL_W'(cell_sum);
        end
    end

    // Store address and range check.
    always_comb begin
        hit_next  = (int'(scale_reg) < NUM_SCALES) && (int'(class_reg) < NUM_CLASSES)
                    && (int'(cell_reg) < CELLS);
        addr_next = (ADDR_W'(scale_reg) * ADDR_W'(CELLS) + ADDR_W'(cell_reg))
                    * ADDR_W'(NUM_CLASSES) + ADDR_W'(class_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            c_reg <= c_next;
            d_reg <= d_next;
        end
        if (cmd.calc) begin
            cell_reg <= cell_next;
        end
        if (cmd.addr) begin
            addr_reg <= addr_next;
            hit_reg  <= hit_next;
        end
    end

    // Saturating increment of the fetched count.
    logic                  sat;
    logic                  do_write;
    logic [COUNT_BITS-1:0] new_count, result_count;
    always_comb begin
        sat       = (req_reg == REQ_BIN) && hit_reg && (rd_data_reg == COUNT_MAX);
        new_count = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                               : rd_data_reg + COUNT_BITS'(1);
        do_write  = cmd.update && (req_reg == REQ_BIN) && hit_reg;
        if (!hit_reg) begin
            result_count = '0;
        end else if (req_reg == REQ_BIN) begin
            result_count = new_count;
        end else begin
            result_count = rd_data_reg;
        end
    end

    // Count store: one write port shared by the clearing sweep and updates.
    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem[clr_addr_reg] <= '0;
        end else if (do_write) begin
            mem[addr_reg] <= new_count;
        end
        if (cmd.read) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            out_cell_reg  <= OUT_CELL_W'(cell_reg);
            out_count_reg <= OUT_COUNT_W'(result_count);
            out_sat_reg   <= sat;
        end
    end

    always_comb begin
        status.clr_last = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
        status.out_free = !m_valid_reg || m_tready;
        m_tvalid        = m_valid_reg;
        m_tdata         = {(M_TDATA_W - OUT_COUNT_W - OUT_CELL_W)'(0),
                           out_count_reg, out_cell_reg};
        m_tuser         = out_sat_reg;
    end

endmodule : tgdh_dp

`default_nettype wire

[rtl/triangle_grid_density_histogram.sv]
// Top level of the triangle grid density histogram: controller, datapath and checks.
//
//  Channel  Dir  Handshake           Payload (lowest bit first)
//  s_       in   s_tvalid/s_tready   tdata: coord_a, coord_b, scale_index,
//                                    class_index, read_cell; tuser: req_type
//  m_       out  m_tvalid/m_tready   tdata: cell_number, count_value;
//                                    tuser: saturated
//  cfg_     in   cfg_wr_en           cfg_wr_data: subdivisions
//
// Each request passes through operand capture, multiply, cell arithmetic, address,
// store read and update before the next request transfer can happen.
// The controller walks one request at a time through these steps.
// After reset the store is swept to zero, one entry a cycle, over all
// NUM_SCALES*MAX_SUBDIV*(MAX_SUBDIV+1)*NUM_CLASSES entries (8704 by default);
// s_tready stays low during the sweep, while configuration writes are taken.
// A finished result sits in the output register. If it is still held when the
// next result is ready, the controller waits in the update step and s_tready
// stays low, so a stalled m_ side delays the next request transfer cycle for cycle.
`timescale 1ns / 1ps
`default_nettype none

module triangle_grid_density_histogram
    import tgdh_pkg::*;
#(
    parameter int MAX_SUBDIV  = DEF_MAX_SUBDIV,
    parameter int NUM_SCALES  = DEF_NUM_SCALES,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Subdivisions register.
    input  wire logic                  cfg_wr_en,
    input  wire logic [SUBDIV_W-1:0]   cfg_wr_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // coord_a[17:0], coord_b[35:18], scale_index[37:36], class_index[40:38],
    // read_cell[49:41], zero fill above.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  wire logic                  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // cell_number[8:0], count_value[32:9], zero fill above.
    output logic [M_TDATA_W-1:0]       m_tdata,
    // saturated[0]
    output logic                       m_tuser
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences one request at a time through the datapath.
    tgdh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the count store, the cell arithmetic and the result register.
    tgdh_dp #(
        .MAX_SUBDIV  (MAX_SUBDIV),
        .NUM_SCALES  (NUM_SCALES),
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

    // A request transfer starts work, so no second transfer follows directly.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while the previous one is in progress");

    // A result is only loaded when the output register is free.
    a_update_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_tvalid || m_tready))
        else $error("result would overwrite a pending transfer");

    // A saturated result always reports the full-scale count.
    a_sat_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[32:9] == 24'hFFFFFF))
        else $error("saturated flag with a count below full scale");

    // Clearing and request work never overlap.
    a_no_clear_while_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> !s_tready && !cmd.update)
        else $error("store sweep overlaps request handling");

endmodule : triangle_grid_density_histogram

`default_nettype wire

[test/triangle_grid_density_histogram_test.sv]
// Self-checking bench for the triangle grid density histogram: binning, reads and subdivisions.
`timescale 1ns / 1ps

module triangle_grid_density_histogram_test;

    import tgdh_pkg::*;

    // Histogram geometry at the default parameters of the block.
    localparam int CELLS_PER_SCALE = DEF_MAX_SUBDIV * (DEF_MAX_SUBDIV + 1);
    localparam int STORE_DEPTH     = DEF_NUM_SCALES * CELLS_PER_SCALE * DEF_NUM_CLASSES;
    localparam int FRAC_ONE        = 1 << FRAC_BITS;
    localparam logic [OUT_COUNT_W-1:0] COUNT_MAX = {OUT_COUNT_W{1'b1}};

    // Bit positions of the request fields inside s_tdata.
    localparam int B_LSB     = COORD_W;
    localparam int SCALE_LSB = 2 * COORD_W;
    localparam int CLASS_LSB = SCALE_LSB + SCALE_W;
    localparam int RCELL_LSB = CLASS_LSB + CLASS_W;

    // Settling time after the last result, so that the datapath is empty.
    localparam int SETTLE_CYCLES = 8;
    // The slowest legal run is far below this: the clearing sweep of 8704 entries
    // plus about 1500 requests, each with its own steps and the longest gaps.
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 190;

    typedef struct {
        bit [OUT_CELL_W-1:0]  cell_no;
        bit [OUT_COUNT_W-1:0] count;
        bit                   sat;
    } bin_result_t;

    // The tally mirrors the count store and the subdivisions register, and keeps
    // the results that the block still owes, oldest first.
    class density_tally;
        bit [SUBDIV_W-1:0]    subdiv;
        bit [OUT_COUNT_W-1:0] counts [STORE_DEPTH];
        bin_result_t          awaited [$];
        int unsigned          failures;

        function new();
            subdiv   = SUBDIV_RESET;
            failures = 0;
        endfunction

        function int unsigned slot_of(bit [SCALE_W-1:0] scale, int unsigned cell_idx,
                                      bit [CLASS_W-1:0] cls);
            return (scale * CELLS_PER_SCALE + cell_idx) * DEF_NUM_CLASSES + cls;
        endfunction

        // Works out the result of one accepted request and applies its increment.
        function void note_request(logic kind, logic signed [COORD_W-1:0] a,
                                   logic signed [COORD_W-1:0] b, logic [SCALE_W-1:0] scale,
                                   logic [CLASS_W-1:0] cls, logic [READ_CELL_W-1:0] rcell);
            longint      n, c, d, x, y;
            bit          lower;
            bit          addr_ok;
            int unsigned slot;
            bin_result_t r;
            r.count = '0;
            r.sat   = 1'b0;
            addr_ok = (scale < DEF_NUM_SCALES) && (cls < DEF_NUM_CLASSES);
            if (kind == REQ_READ) begin
                r.cell_no = rcell;
                if (addr_ok && rcell < CELLS_PER_SCALE) begin
                    r.count = counts[slot_of(scale, rcell, cls)];
                end
            end else begin
                n = longint'(subdiv);
                if (n < 1) n = 1;
                if (n > DEF_MAX_SUBDIV) n = DEF_MAX_SUBDIV;
                c = n * (longint'(FRAC_ONE) - longint'(a));
                d = n * (longint'(FRAC_ONE) - longint'(a) - longint'(b));
                // Arithmetic shift floors toward minus infinity, as the cell grid needs.
                x = c >>> FRAC_BITS;
                y = d >>> FRAC_BITS;
                lower = (c & (FRAC_ONE - 1)) > (d & (FRAC_ONE - 1));
                if (x >= n) begin x = n - 1; lower = 1'b1; end
                if (x < 0)  begin x = 0;     lower = 1'b1; end
                if (y >= n) begin y = n - 1; lower = 1'b1; end
                if (y < 0)  begin y = 0;     lower = 1'b1; end
                if (y > x)  begin y = x;     lower = 1'b1; end
                r.cell_no = OUT_CELL_W'((x * (x + 1) / 2 + y) * 2 + lower);
                if (addr_ok && r.cell_no < CELLS_PER_SCALE) begin
                    slot = slot_of(scale, r.cell_no, cls);
                    if (counts[slot] == COUNT_MAX) begin
                        r.sat = 1'b1;
                    end else begin
                        counts[slot]++;
                    end
                    r.count = counts[slot];
                end
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(logic [OUT_CELL_W-1:0] cell_no,
                                   logic [OUT_COUNT_W-1:0] count, logic sat);
            bin_result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result cell %0d count %0d saturated %b",
                         $time, cell_no, count, sat);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (cell_no !== want.cell_no) begin
                $display("%0t: cell_number expected %0d, actual %0d", $time, want.cell_no,
                         cell_no);
                failures++;
            end
            if (count !== want.count) begin
                $display("%0t: count_value expected %0d, actual %0d", $time, want.count, count);
                failures++;
            end
            if (sat !== want.sat) begin
                $display("%0t: saturated expected %b, actual %b", $time, want.sat, sat);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [SUBDIV_W-1:0]    cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    density_tally tally;
    // When set, the matching side runs without any idle cycles.
    bit          source_steady;
    bit          sink_steady;
    int unsigned cycle_count;

    triangle_grid_density_histogram uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offers one request from a falling edge and returns at the falling edge after
    // its transfer, with the chosen gap already spent. s_tvalid stays high when no
    // gap follows, so back-to-back requests never pulse it low.
    task automatic send_request(input logic kind, input logic signed [COORD_W-1:0] a,
                                input logic signed [COORD_W-1:0] b,
                                input logic [SCALE_W-1:0] scale, input logic [CLASS_W-1:0] cls,
                                input logic [READ_CELL_W-1:0] rcell);
        logic [S_TDATA_W-1:0] word;
        int unsigned          gap;
        word = '0;
        word[B_LSB-1:0]                   = a;
        word[SCALE_LSB-1:B_LSB]           = b;
        word[CLASS_LSB-1:SCALE_LSB]       = scale;
        word[RCELL_LSB-1:CLASS_LSB]       = cls;
        word[RCELL_LSB+READ_CELL_W-1:RCELL_LSB] = rcell;
        s_tdata  = word;
        s_tuser  = kind;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tally.note_request(kind, a, b, scale, cls, rcell);
        @(negedge aclk);
        gap = source_steady ? 0 : idle_cycles();
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Holds the sender back until every owed result has come out, then lets the
    // datapath settle so that a register write finds the block idle.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tally.awaited.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_subdivisions(input logic [SUBDIV_W-1:0] value);
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        tally.subdiv = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // One random request. Most bins land inside the unit triangle, where the cell
    // arithmetic is exercised without clamping; the rest graze the edges or take
    // any coordinate at all. Half the traffic lands in scale 0, classes 0 and 1, so counts grow.
    task automatic random_request();
        int unsigned           roll;
        int                    ia;
        int                    ib;
        logic [SCALE_W-1:0]    scale;
        logic [CLASS_W-1:0]    cls;
        logic [READ_CELL_W-1:0] rcell;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0) begin
            scale = '0;
            cls   = CLASS_W'($urandom_range(0, 1));
        end else begin
            scale = SCALE_W'($urandom());
            cls   = CLASS_W'($urandom());
        end
        rcell = READ_CELL_W'(($urandom_range(0, 6) == 0)
                             ? $urandom_range(0, (1 << READ_CELL_W) - 1)
                             : $urandom_range(0, CELLS_PER_SCALE - 1));
        if (roll < 20) begin
            send_request(REQ_READ, COORD_W'($urandom()), COORD_W'($urandom()), scale, cls,
                         rcell);
        end else begin
            if (roll < 75) begin
                ia = $urandom_range(0, FRAC_ONE);
                ib = $urandom_range(0, FRAC_ONE - ia);
            end else if (roll < 88) begin
                ia = $urandom_range(0, FRAC_ONE + 4000) - 2000;
                ib = $urandom_range(0, FRAC_ONE + 4000) - 2000;
            end else begin
                ia = $urandom_range(0, (1 << COORD_W) - 1) - (1 << (COORD_W - 1));
                ib = $urandom_range(0, (1 << COORD_W) - 1) - (1 << (COORD_W - 1));
            end
            send_request(REQ_BIN, COORD_W'(ia), COORD_W'(ib), scale, cls, rcell);
        end
        if ($urandom_range(0, 149) == 0) wait_drained();
    endtask

    // Result side: m_tready follows its own stall pattern, changing only at
    // falling edges, and each transfer is checked at the rising edge it happens on.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_steady) begin
                m_tready = 1'b1;
            end else if (stall_left != 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = idle_cycles();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tally.check_result(m_tdata[OUT_CELL_W-1:0],
                               m_tdata[OUT_CELL_W+OUT_COUNT_W-1:OUT_CELL_W], m_tuser);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[triangle_grid_density_histogram] ERROR");
        $finish;
    end

    initial begin
        logic [SUBDIV_W-1:0] phase_subdiv [PHASES];
        phase_subdiv = '{5'd5, 5'd16, 5'd1, 5'd0, 5'd31, 5'd12, 5'd3, 5'd9};
        tally         = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_BIN;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, first at the reset value of eight subdivisions. The first
        // transfer only happens once the clearing sweep is over.
        // The origin lies on a corner of the triangle and clamps into the cell there.
        send_request(REQ_BIN, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd0);
        send_request(REQ_BIN, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd0);
        // a = 1.0 gives the apex cell with equal fractions.
        send_request(REQ_BIN, 18'sd65536, 18'sd0, 2'd3, 3'd7, 9'd511);
        // The coordinate extremes, all clamped.
        send_request(REQ_BIN, -18'sd131072, -18'sd131072, 2'd1, 3'd2, 9'd0);
        send_request(REQ_BIN, 18'sd131071, 18'sd131071, 2'd2, 3'd5, 9'd0);
        send_request(REQ_BIN, -18'sd131072, 18'sd131071, 2'd0, 3'd1, 9'd0);
        send_request(REQ_BIN, 18'sd32768, 18'sd16384, 2'd0, 3'd0, 9'd0);
        send_request(REQ_READ, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd71);
        send_request(REQ_READ, -18'sd1, -18'sd1, 2'd3, 3'd7, 9'd0);
        // Cells past the end of a scale plane read as zero.
        send_request(REQ_READ, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd272);
        send_request(REQ_READ, 18'sd0, 18'sd0, 2'd3, 3'd7, 9'd511);
        wait_drained();

        // Zero subdivisions behave as one.
        write_subdivisions(5'd0);
        send_request(REQ_BIN, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd0);
        send_request(REQ_BIN, 18'sd40000, 18'sd10000, 2'd0, 3'd0, 9'd0);
        send_request(REQ_READ, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd1);
        wait_drained();

        // Values above the maximum saturate to sixteen; these reach the last cells.
        write_subdivisions(5'd31);
        send_request(REQ_BIN, 18'sd1, 18'sd1, 2'd3, 3'd7, 9'd0);
        send_request(REQ_BIN, 18'sd1, 18'sd0, 2'd3, 3'd7, 9'd0);
        send_request(REQ_READ, 18'sd0, 18'sd0, 2'd3, 3'd7, 9'd271);
        wait_drained();

        // Counts survive a change of subdivisions.
        write_subdivisions(5'd17);
        send_request(REQ_BIN, 18'sd65535, 18'sd1, 2'd3, 3'd7, 9'd0);
        send_request(REQ_READ, 18'sd0, 18'sd0, 2'd0, 3'd0, 9'd71);
        wait_drained();
        write_subdivisions(5'd16);
        send_request(REQ_BIN, 18'sd20000, 18'sd30000, 2'd2, 3'd3, 9'd0);
        wait_drained();
        write_subdivisions(5'd1);
        send_request(REQ_BIN, 18'sd0, 18'sd65536, 2'd1, 3'd6, 9'd0);

        // Random part: one subdivisions setting per phase, and in some phases one
        // or both sides run without idle cycles.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_subdivisions(p == PHASES - 1 ? SUBDIV_W'($urandom()) : phase_subdiv[p]);
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                random_request();
            end
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        if (tally.failures == 0) begin
            $display("[triangle_grid_density_histogram] OK");
        end else begin
            $display("[triangle_grid_density_histogram] ERROR");
        end
        $finish;
    end

endmodule
